// File: design/tabulated_evaporation_energy_sampler_core_macros.svh
// Assertion macros for the evaporation sampler checker.
// Each samples on i_clk and is switched off while i_rst_n is low.
`ifndef TABULATED_EVAPORATION_ENERGY_SAMPLER_CORE_MACROS_SVH
`define TABULATED_EVAPORATION_ENERGY_SAMPLER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TEES_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TEES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/tees_pkg.sv
// ----------------------------------------------------------------------------
// tees_pkg
// Shared constants for the tabulated evaporation energy sampler.
// ----------------------------------------------------------------------------
package tees_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = 7;
    localparam int WORD_W        = 32;
    localparam int FRAC_W        = 17;
    localparam int OPC_W         = 2;

    // opcodes
    localparam logic [OPC_W-1:0] OP_LOAD_SCALE  = 2'd0;
    localparam logic [OPC_W-1:0] OP_LOAD_SAMPLE = 2'd1;
    localparam logic [OPC_W-1:0] OP_SAMPLE      = 2'd2;

    // configuration register indexes
    localparam logic CFG_SCALE_CNT  = 1'b0;
    localparam logic CFG_SAMPLE_CNT = 1'b1;

endpackage

// File: design/tees_ram.sv
// ----------------------------------------------------------------------------
// tees_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module tees_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/tabulated_evaporation_energy_sampler_core.sv
// ----------------------------------------------------------------------------
// tabulated_evaporation_energy_sampler_core
// Two sorted key/value tables, binary search and linear interpolation,
// product of the two lookups in unsigned Q16.16 with saturation.
//
//  channel   handshake             payload
//  input     start & !busy         i_opcode, i_entry_*, i_incident_energy,
//                                  i_random_fraction
//  result    o_valid (one cycle)   o_emitted_energy, o_saturated
//  config    i_cfg_we              i_cfg_index, i_cfg_wdata
//
// Load words leave busy low. A sample word keeps busy high through both
// lookups, each of at most 6 search steps, and the product; its run is set
// by the 32-step shared divider and the one-port table reads. A lookup
// outside the grid skips the search and the divider, an empty bin the divider.
// The result strobe comes in the same cycle as busy falls.
// Synchronous active-low reset sets both counts to 2; tables are undefined
// until loaded. The receiver cannot stall: the result shows for one cycle.
// ----------------------------------------------------------------------------
module tabulated_evaporation_energy_sampler_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [tees_pkg::OPC_W-1:0] i_opcode,
    input  logic [tees_pkg::IDX_W-1:0] i_entry_index,
    input  logic [31:0]                i_entry_key,
    input  logic [31:0]                i_entry_value,
    input  logic [31:0]                i_incident_energy,
    input  logic [16:0]                i_random_fraction,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [tees_pkg::CNT_W-1:0] i_cfg_wdata,
    output logic                       o_valid,
    output logic [31:0]                o_emitted_energy,
    output logic                       o_saturated
);
    import tees_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE = 13'h0001,
        S_A0   = 13'h0002,
        S_A1   = 13'h0004,
        S_A2   = 13'h0008,
        S_SRCH = 13'h0010,
        S_CMP  = 13'h0020,
        S_L0   = 13'h0040,
        S_L1   = 13'h0080,
        S_MUL  = 13'h0100,
        S_DIV  = 13'h0200,
        S_INTP = 13'h0400,
        S_PMUL = 13'h0800,
        S_OUT  = 13'h1000
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_scale_cnt, r_sample_cnt;
    logic [WORD_W-1:0] r_x, r_energy, r_k0, r_v0, r_a, r_b, r_div;
    logic [WORD_W-1:0] r_rem, r_quo, r_xs, r_out;
    logic [2*WORD_W-1:0] r_prod;
    logic [IDX_W-1:0]  r_lo, r_hi;
    logic [4:0]        r_cnt;
    logic              r_tsel, r_neg, r_valid, r_sat;

    logic                  accept, load_scale, load_sample;
    logic [2*WORD_W-1:0]   wdata, scale_rdata, sample_rdata, rdata, mul;
    logic [WORD_W-1:0]     rkey, rval, lu_res, width, off;
    logic                  lu_done;
    logic [IDX_W-1:0]      raddr, last, mid;
    logic [CNT_W-1:0]      cnt_sel, cnt_eff;
    logic [IDX_W:0]        lohi_sum;
    logic [WORD_W:0]       div_t, div_d;
    logic                  div_ge;

    assign accept      = start && !busy;
    assign load_scale  = accept && (i_opcode == OP_LOAD_SCALE);
    assign load_sample = accept && (i_opcode == OP_LOAD_SAMPLE);
    assign wdata       = {i_entry_key, i_entry_value};

    // table memories, key in the upper half
    tees_ram #(.WIDTH(2*WORD_W), .DEPTH(TABLE_ENTRIES)) u_scale_ram (
        .i_clk  (i_clk),
        .i_we   (load_scale),
        .i_waddr(i_entry_index),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(scale_rdata)
    );

    tees_ram #(.WIDTH(2*WORD_W), .DEPTH(TABLE_ENTRIES)) u_sample_ram (
        .i_clk  (i_clk),
        .i_we   (load_sample),
        .i_waddr(i_entry_index),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(sample_rdata)
    );

    assign rdata = r_tsel ? sample_rdata : scale_rdata;
    assign rkey  = rdata[2*WORD_W-1:WORD_W];
    assign rval  = rdata[WORD_W-1:0];

    // effective count clamped to 2..TABLE_ENTRIES
    assign cnt_sel = r_tsel ? r_sample_cnt : r_scale_cnt;
    always_comb begin
        if (cnt_sel < CNT_W'(2)) begin
            cnt_eff = CNT_W'(2);
        end else if (cnt_sel > CNT_W'(TABLE_ENTRIES)) begin
            cnt_eff = CNT_W'(TABLE_ENTRIES);
        end else begin
            cnt_eff = cnt_sel;
        end
    end
    assign last     = IDX_W'(cnt_eff - CNT_W'(1));
    assign lohi_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = lohi_sum[IDX_W:1];

    // shared multiplier and divider step
    assign mul    = r_a * r_b;
    assign div_t  = {r_rem, r_quo[WORD_W-1]};
    assign div_d  = {1'b0, r_div};
    assign div_ge = div_t >= div_d;

    // bin interpolation operands
    assign width = rkey - r_k0;
    always_comb begin
        if (r_x < r_k0) begin
            off = '0;
        end else if ((r_x - r_k0) > width) begin
            off = width;
        end else begin
            off = r_x - r_k0;
        end
    end

    // read address per state
    always_comb begin
        unique case (r_state)
            S_A1:    raddr = last;
            S_SRCH:  raddr = (r_hi - r_lo > IDX_W'(1)) ? mid : r_lo;
            S_L0:    raddr = r_lo + IDX_W'(1);
            default: raddr = '0;
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        lu_done = 1'b0;
        lu_res  = r_v0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_opcode == OP_SAMPLE)) n_state = S_A0;
            end
            S_A0: n_state = S_A1;
            S_A1: n_state = S_A2;
            S_A2: begin
                if (r_x < r_k0) begin
                    lu_done = 1'b1;
                end else if (r_x > rkey) begin
                    lu_done = 1'b1;
                    lu_res  = rval;
                end else begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: n_state = (r_hi - r_lo > IDX_W'(1)) ? S_CMP : S_L0;
            S_CMP:  n_state = S_SRCH;
            S_L0:   n_state = S_L1;
            S_L1: begin
                if (rkey <= r_k0) lu_done = 1'b1;
                else n_state = S_MUL;
            end
            S_MUL: n_state = S_DIV;
            S_DIV: if (r_cnt == 5'd31) n_state = S_INTP;
            S_INTP: begin
                lu_done = 1'b1;
                lu_res  = r_neg ? (r_v0 - r_quo) : (r_v0 + r_quo);
            end
            S_PMUL: n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (lu_done) n_state = r_tsel ? S_A0 : S_PMUL;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= 1'b0;
            r_scale_cnt  <= CNT_W'(2);
            r_sample_cnt <= CNT_W'(2);
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_OUT);
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_SCALE_CNT) r_scale_cnt <= i_cfg_wdata;
                if (i_cfg_index == CFG_SAMPLE_CNT) r_sample_cnt <= i_cfg_wdata;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_tsel   <= 1'b1;
                r_x      <= {{(WORD_W-FRAC_W){1'b0}}, i_random_fraction};
                r_energy <= i_incident_energy;
            end
            S_A1: begin
                r_k0 <= rkey;
                r_v0 <= rval;
            end
            S_A2: begin
                r_lo <= '0;
                r_hi <= last;
            end
            S_CMP: begin
                if (rkey <= r_x) r_lo <= mid;
                else r_hi <= mid;
            end
            S_L0: begin
                r_k0 <= rkey;
                r_v0 <= rval;
            end
            S_L1: begin
                // empty bin ends the lookup and leaves the operands alone
                if (!lu_done) begin
                    r_neg <= rval < r_v0;
                    r_a   <= (rval < r_v0) ? (r_v0 - rval) : (rval - r_v0);
                    r_b   <= off;
                    r_div <= width;
                end
            end
            S_MUL: begin
                r_rem <= mul[2*WORD_W-1:WORD_W];
                r_quo <= mul[WORD_W-1:0];
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= div_ge ? WORD_W'(div_t - div_d) : div_t[WORD_W-1:0];
                r_quo <= {r_quo[WORD_W-2:0], div_ge};
                r_cnt <= r_cnt + 5'd1;
            end
            S_PMUL: r_prod <= mul;
            S_OUT: begin
                r_sat <= |r_prod[2*WORD_W-1:48];
                r_out <= (|r_prod[2*WORD_W-1:48]) ? '1 : r_prod[47:16];
            end
            default: ;
        endcase
        // end of one lookup: sample table first, then scale table
        if (lu_done) begin
            if (r_tsel) begin
                r_xs   <= lu_res;
                r_tsel <= 1'b0;
                r_x    <= r_energy;
            end else begin
                r_a <= lu_res;
                r_b <= r_xs;
            end
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_emitted_energy = r_out;
    assign o_saturated      = r_sat;

endmodule

// File: design/tees_chk.sv
// ----------------------------------------------------------------------------
// tees_chk
// Port-level checks on the sampler core, bound to the top level.
// ----------------------------------------------------------------------------
`include "tabulated_evaporation_energy_sampler_core_macros.svh"

module tees_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [tees_pkg::OPC_W-1:0] i_opcode,
    input logic                       o_valid,
    input logic [31:0]                o_emitted_energy,
    input logic                       o_saturated
);
    import tees_pkg::*;

    logic sample_acc, other_acc, sat_shown, all_ones;

    assign sample_acc = start && !busy && (i_opcode == OP_SAMPLE);
    assign other_acc  = start && !busy && (i_opcode != OP_SAMPLE);
    assign sat_shown  = o_valid && o_saturated;
    assign all_ones   = (o_emitted_energy == 32'hFFFF_FFFF);

    // a sample word makes the core busy
    `TEES_ASSERT_NEXT(a_sample_busy, sample_acc, busy, "sample word did not raise busy")

    // load and unused words complete at once
    `TEES_ASSERT_NEXT(a_load_idle, other_acc, !busy, "non-sample word raised busy")

    // result strobe lasts one cycle and comes with the core idle
    `TEES_ASSERT_NEXT(a_strobe_once, o_valid, !o_valid, "result strobe longer than one cycle")
    `TEES_ASSERT_SAME(a_strobe_idle, o_valid, !busy, "result shown while busy")

    // a saturated result is all ones
    `TEES_ASSERT_SAME(a_sat_value, sat_shown, all_ones, "saturated result not all ones")

endmodule

bind tabulated_evaporation_energy_sampler_core tees_chk u_tees_chk (.*);

// File: verif/tees_scoreboard.sv
// ----------------------------------------------------------------------------
// tees_scoreboard
// Watches the command, result and register channels of the evaporation
// sampler, keeps its own copy of both tables and counts, predicts each sample
// word and compares every result word field by field, in order.
// ----------------------------------------------------------------------------
module tees_scoreboard (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic [tees_pkg::OPC_W-1:0] i_opcode,
    input  logic [tees_pkg::IDX_W-1:0] i_entry_index,
    input  logic [31:0]                i_entry_key,
    input  logic [31:0]                i_entry_value,
    input  logic [31:0]                i_incident_energy,
    input  logic [16:0]                i_random_fraction,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [tees_pkg::CNT_W-1:0] i_cfg_wdata,
    input  logic                       o_valid,
    input  logic [31:0]                o_emitted_energy,
    input  logic                       o_saturated,
    output int                         o_pending,
    output int                         o_fail_count
);
    import tees_pkg::*;

    typedef logic [31:0] t_word;
    typedef t_word t_tab [TABLE_ENTRIES];

    typedef struct packed {
        logic [31:0] energy;
        logic        sat;
    } t_sample_word;

    t_tab           scale_keys_m, scale_vals_m, sample_keys_m, sample_vals_m;
    logic [CNT_W-1:0] scale_cnt_m, sample_cnt_m;
    t_sample_word   energy_q [$];

    // interpolated table lookup, clamped to the end values outside the grid
    function automatic t_word table_interp(input t_tab k, input t_tab v,
                                           input logic [CNT_W-1:0] cnt,
                                           input t_word x);
        int n, lo, hi, mid;
        t_word k0, k1, v0, v1, span, offs;
        longint unsigned mag, quo;
        n = (cnt < 2) ? 2 : ((cnt > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(cnt));
        lo = 0;
        hi = n - 1;
        if (x < k[0]) return v[0];
        if (x > k[n-1]) return v[n-1];
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (k[mid] <= x) lo = mid; else hi = mid;
        end
        k0 = k[lo];
        k1 = k[lo+1];
        v0 = v[lo];
        v1 = v[lo+1];
        // empty bin
        if (k1 <= k0) return v0;
        span = k1 - k0;
        offs = (x < k0) ? 32'd0 : x - k0;
        if (offs > span) offs = span;
        if (v1 >= v0) begin
            mag = longint'(v1 - v0) * longint'(offs);
            quo = mag / longint'(span);
            return v0 + t_word'(quo);
        end
        mag = longint'(v0 - v1) * longint'(offs);
        quo = mag / longint'(span);
        return v0 - t_word'(quo);
    endfunction

    function automatic t_sample_word predict_energy(input t_word en,
                                                    input logic [16:0] fr);
        t_word t, xs;
        longint unsigned prod;
        t_sample_word r;
        xs = table_interp(sample_keys_m, sample_vals_m, sample_cnt_m, t_word'(fr));
        t  = table_interp(scale_keys_m, scale_vals_m, scale_cnt_m, en);
        prod = (longint'(t) * longint'(xs)) >> 16;
        if (prod > 64'hFFFF_FFFF) begin
            r.energy = 32'hFFFF_FFFF;
            r.sat    = 1'b1;
        end else begin
            r.energy = prod[31:0];
            r.sat    = 1'b0;
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what, input t_word got, input t_word want);
        $display("mismatch: %s got %h want %h", what, got, want);
        o_fail_count = o_fail_count + 1;
    endtask

    initial o_fail_count = 0;

    // compare results first, then record the newly accepted word
    always @(posedge i_clk) begin
        t_sample_word want;
        if (!i_rst_n) begin
            scale_cnt_m  <= CNT_W'(2);
            sample_cnt_m <= CNT_W'(2);
            energy_q.delete();
            o_pending    <= 0;
        end else begin
            if (o_valid) begin
                if (energy_q.size() == 0) begin
                    note_mismatch("unexpected result word", o_emitted_energy, 32'd0);
                end else begin
                    want = energy_q.pop_front();
                    if (o_emitted_energy !== want.energy)
                        note_mismatch("emitted_energy", o_emitted_energy, want.energy);
                    if (o_saturated !== want.sat)
                        note_mismatch("saturated", t_word'(o_saturated), t_word'(want.sat));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_SCALE_CNT) scale_cnt_m <= i_cfg_wdata;
                else                              sample_cnt_m <= i_cfg_wdata;
            end
            if (start && !busy) begin
                case (i_opcode)
                    OP_LOAD_SCALE: begin
                        scale_keys_m[i_entry_index] = i_entry_key;
                        scale_vals_m[i_entry_index] = i_entry_value;
                    end
                    OP_LOAD_SAMPLE: begin
                        sample_keys_m[i_entry_index] = i_entry_key;
                        sample_vals_m[i_entry_index] = i_entry_value;
                    end
                    OP_SAMPLE:
                        energy_q.push_back(predict_energy(i_incident_energy,
                                                          i_random_fraction));
                    default: ;
                endcase
            end
            o_pending <= energy_q.size();
        end
    end

endmodule

// File: verif/tb_tabulated_evaporation_energy_sampler_core.sv
// ----------------------------------------------------------------------------
// tb_tabulated_evaporation_energy_sampler_core
// Loads both tables, runs directed corner words, then random phases over a
// range of table counts with bursty command traffic. Checking is done by the
// scoreboard instance; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_tabulated_evaporation_energy_sampler_core;
    import tees_pkg::*;

    localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_LIMIT   = 4000;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 55;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [OPC_W-1:0]   i_opcode;
    logic [IDX_W-1:0]   i_entry_index;
    logic [31:0]        i_entry_key;
    logic [31:0]        i_entry_value;
    logic [31:0]        i_incident_energy;
    logic [16:0]        i_random_fraction;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [CNT_W-1:0]   i_cfg_wdata;
    logic               o_valid;
    logic [31:0]        o_emitted_energy;
    logic               o_saturated;
    int                 pending;
    int                 fail_count;
    int                 idle_cycles;
    int                 burst_left;

    // keys as loaded, used only to aim the stimulus at the grids
    logic [31:0]        scale_grid [TABLE_ENTRIES];
    logic [31:0]        sample_grid [TABLE_ENTRIES];
    int                 scale_n, sample_n;

    tabulated_evaporation_energy_sampler_core dut (.*);

    tees_scoreboard u_scoreboard (
        .*,
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // watchdog: ends the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one command word, with bursts and random gaps in between
    task automatic send_word(input logic [OPC_W-1:0] op, input logic [IDX_W-1:0] idx,
                             input logic [31:0] key, input logic [31:0] val,
                             input logic [31:0] en, input logic [16:0] fr);
        int gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        start             <= 1'b1;
        i_opcode          <= op;
        i_entry_index     <= idx;
        i_entry_key       <= key;
        i_entry_value     <= val;
        i_incident_energy <= en;
        i_random_fraction <= fr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        burst_left = burst_left - 1;
    endtask

    task automatic load_entry(input logic [OPC_W-1:0] op, input int idx,
                              input logic [31:0] key, input logic [31:0] val);
        if (op == OP_LOAD_SCALE) scale_grid[idx] = key;
        else                     sample_grid[idx] = key;
        send_word(op, idx[IDX_W-1:0], key, val, $urandom, 17'($urandom));
    endtask

    task automatic sample_word(input logic [31:0] en, input logic [16:0] fr);
        send_word(OP_SAMPLE, 6'($urandom), $urandom, $urandom, en, fr);
    endtask

    // hold off until every result is in and the block has settled
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_counts(input int scale_c, input int sample_c);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SCALE_CNT;
        i_cfg_wdata <= CNT_W'(scale_c);
        @(posedge i_clk);
        i_cfg_index <= CFG_SAMPLE_CNT;
        i_cfg_wdata <= CNT_W'(sample_c);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        scale_n  = (scale_c < 2) ? 2 : ((scale_c > TABLE_ENTRIES) ? TABLE_ENTRIES : scale_c);
        sample_n = (sample_c < 2) ? 2 : ((sample_c > TABLE_ENTRIES) ? TABLE_ENTRIES : sample_c);
    endtask

    function automatic logic [31:0] rand_value();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    // full reload of both tables with ascending keys
    task automatic fill_tables();
        longint unsigned step, k;
        step = $urandom_range(1, 32'h03F0_0000);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            k = longint'(i) * step + $urandom_range(0, 32'(step - 1));
            load_entry(OP_LOAD_SCALE, i, k[31:0], rand_value());
        end
        step = $urandom_range(1, 2100);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            k = longint'(i) * step + $urandom_range(0, 32'(step - 1));
            load_entry(OP_LOAD_SAMPLE, i, k[31:0], rand_value());
        end
    endtask

    // random reload of one entry, mostly keeping the keys in order
    task automatic reload_entry(input logic [OPC_W-1:0] op);
        int idx;
        logic [31:0] lo_k, hi_k, key;
        idx = $urandom_range(0, TABLE_ENTRIES - 1);
        if (op == OP_LOAD_SCALE) begin
            lo_k = (idx == 0) ? 32'd0 : scale_grid[idx-1];
            hi_k = (idx == TABLE_ENTRIES - 1) ? 32'hFFFF_FFFF : scale_grid[idx+1];
        end else begin
            lo_k = (idx == 0) ? 32'd0 : sample_grid[idx-1];
            hi_k = (idx == TABLE_ENTRIES - 1) ? 32'h0002_0000 : sample_grid[idx+1];
        end
        if ($urandom_range(0, 9) == 0 || lo_k > hi_k) key = $urandom;
        else key = $urandom_range(hi_k, lo_k);
        load_entry(op, idx, key, rand_value());
    endtask

    task automatic random_sample();
        logic [31:0] en, lo_k, hi_k;
        logic [16:0] fr;
        int sel;
        sel = $urandom_range(0, 19);
        lo_k = scale_grid[0];
        hi_k = scale_grid[scale_n-1];
        if (sel < 12 && lo_k <= hi_k) en = $urandom_range(hi_k, lo_k);
        else if (sel < 15) en = scale_grid[$urandom_range(0, scale_n - 1)];
        else en = $urandom;
        lo_k = sample_grid[0];
        hi_k = sample_grid[sample_n-1];
        if ($urandom_range(0, 9) < 7 && lo_k <= hi_k && hi_k < 32'h0002_0000)
            fr = 17'($urandom_range(hi_k, lo_k));
        else
            fr = 17'($urandom_range(0, 17'h1_FFFF));
        sample_word(en, fr);
    endtask

    initial begin
        int scale_set  [PHASES];
        int sample_set [PHASES];
        int sel;
        scale_set         = '{64, 2, 0, 127, 1, 65, 7, 33};
        sample_set        = '{64, 1, 2, 100, 127, 0, 17, 5};
        start             <= 1'b0;
        i_opcode          <= OP_LOAD_SCALE;
        i_entry_index     <= '0;
        i_entry_key       <= '0;
        i_entry_value     <= '0;
        i_incident_energy <= '0;
        i_random_fraction <= '0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= CFG_SCALE_CNT;
        i_cfg_wdata       <= '0;
        i_rst_n           <= 1'b0;
        burst_left        = 0;
        scale_n           = 2;
        sample_n          = 2;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        fill_tables();

        // directed corners at the reset counts of two entries
        load_entry(OP_LOAD_SCALE, 0, 32'h0001_0000, 32'hFFFF_FFFF);
        load_entry(OP_LOAD_SCALE, 1, 32'h0001_0000, 32'h0000_1234);
        load_entry(OP_LOAD_SAMPLE, 0, 32'h0000_0000, 32'hFFFF_FFFF);
        load_entry(OP_LOAD_SAMPLE, 1, 32'h0001_0000, 32'h0000_0000);
        sample_word(32'h0001_0000, 17'h0_8000);   // empty bin, interior fraction
        sample_word(32'h0000_0000, 17'h0_0000);   // below grid, full product saturates
        sample_word(32'hFFFF_FFFF, 17'h1_0000);   // above grid, fraction of one
        sample_word(32'h0000_0001, 17'h1_FFFF);   // fraction above one clamps
        send_word(OP_UNUSED, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'h1_FFFF);
        load_entry(OP_LOAD_SCALE, 0, 32'h0000_0000, 32'h0000_0000);
        load_entry(OP_LOAD_SCALE, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        sample_word(32'h8000_0000, 17'h0_4000);
        sample_word(32'hFFFF_FFFF, 17'h0_0001);
        // unsorted keys over three entries
        load_entry(OP_LOAD_SCALE, 1, 32'h0000_0300, 32'h0001_0000);
        load_entry(OP_LOAD_SCALE, 2, 32'h0000_0100, 32'h0002_0000);
        write_counts(3, 2);
        sample_word(32'h0000_0080, 17'h0_C000);
        sample_word(32'h0000_0100, 17'h0_2000);
        send_word(OP_UNUSED, 6'h00, 32'h0, 32'h0, 32'h0, 17'h0);

        // random phases; the pause for all results is part of each switch
        for (int p = 0; p < PHASES; p++) begin
            write_counts(scale_set[p], sample_set[p]);
            if (p == 3) begin
                fill_tables();
                write_counts(scale_set[p], sample_set[p]);
            end
            for (int w = 0; w < PHASE_WORDS; w++) begin
                sel = $urandom_range(0, 99);
                if (sel < 85)      random_sample();
                else if (sel < 90) reload_entry(OP_LOAD_SCALE);
                else if (sel < 95) reload_entry(OP_LOAD_SAMPLE);
                else send_word(OP_UNUSED, 6'($urandom), $urandom, $urandom,
                               $urandom, 17'($urandom));
            end
        end

        wait_idle();
        repeat (120) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
